[hdl/kmpfm_pkg.sv]
// Package: sizes, codes and payload types for the KMP first-match search block.
`timescale 1ns / 1ps
package kmpfm_pkg;

   localparam int MAX_PATTERN   = 64;
   localparam int IDX_BITS      = $clog2(MAX_PATTERN);
   localparam int LEN_BITS      = IDX_BITS + 1;
   localparam int DATA_BITS     = 8;
   localparam int POSITION_BITS = 20;
   localparam int TPOS_BITS     = POSITION_BITS + 1;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PAT_LONG  = 2'd2;
   localparam logic [1:0] ST_TEXT_LONG = 2'd3;

   typedef struct packed {
      logic                 op;
      logic [DATA_BITS-1:0] data_byte;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [POSITION_BITS-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic                chase;
      logic [LEN_BITS-1:0] next_k;
   } step_type;

endpackage

[hdl/kmpfm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kmpfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/kmpfm_step.sv]
// Shared KMP step unit: compare one stored byte and pick the next prefix length.
`timescale 1ns / 1ps
module kmpfm_step (
   input  logic [kmpfm_pkg::LEN_BITS-1:0]  k,
   input  logic [kmpfm_pkg::DATA_BITS-1:0] pat_byte,
   input  logic [kmpfm_pkg::LEN_BITS-1:0]  fail_k,
   input  logic [kmpfm_pkg::DATA_BITS-1:0] c,
   input  logic [kmpfm_pkg::LEN_BITS-1:0]  limit,
   output kmpfm_pkg::step_type             step
);
   import kmpfm_pkg::*;

   logic hit;

   assign hit = (pat_byte == c);

   always_comb begin
      step.chase = (k != '0) && !hit;
      if (step.chase) begin
         step.next_k = fail_k;
      end else if ((k < limit) && hit) begin
         step.next_k = k + LEN_BITS'(1);
      end else begin
         step.next_k = k;
      end
   end

endmodule

[hdl/kmp_first_match_search.sv]
// Top level: KMP pattern loader and first-match text scanner with result register.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data): op selects a pattern byte
//    or a text byte, last closes the pattern or the text. A pattern byte after a
//    closed pattern starts a new pattern; a text byte closes an open pattern.
//  - Response channel (rsp_valid / rsp_stall / rsp_data): at most one response per
//    request: found with start position, not found at the end of text, pattern too
//    long, or text too long. Position is zero for every status but found.
//  - A request that needs a compare takes its failure-link steps and then one compare,
//    all done by the single step unit reading the pattern and failure RAMs at one
//    address each per cycle. A request that needs no compare does not enter the
//    scan state. A request that yields a response then passes through the emit
//    state, which loads the output register. req_stall is high while a request is
//    in work.
//  - When the receiver holds rsp_stall, the response stays in the output
//    register; the block takes further requests until it has a new response to
//    deliver, and then waits for the output register to free.
//  - Synchronous reset empties the pattern and the text state and drops any
//    pending response; the RAMs keep their contents, unread until rewritten.
`timescale 1ns / 1ps
module kmp_first_match_search (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  kmpfm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kmpfm_pkg::rsp_type rsp_data
);
   import kmpfm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [DATA_BITS-1:0] c_ff, c_in;
   logic                 last_ff, last_in;
   logic [LEN_BITS-1:0]  k_ff, k_in;
   logic [LEN_BITS-1:0]  pat_len_ff, pat_len_in;
   logic [LEN_BITS-1:0]  pre_idx_ff, pre_idx_in;
   logic [LEN_BITS-1:0]  match_ff, match_in;
   logic [TPOS_BITS-1:0] pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic                 closed_ff, closed_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [DATA_BITS-1:0] wr_pat;
   logic [LEN_BITS-1:0]  wr_fail;
   logic [IDX_BITS-1:0]  rd_pat_addr;
   logic [IDX_BITS-1:0]  rd_fail_addr;
   logic [DATA_BITS-1:0] pat_byte;
   logic [LEN_BITS-1:0]  fail_k;
   logic [LEN_BITS-1:0]  eff_len;
   logic                 tail_en;
   logic                 tail_last;
   logic [TPOS_BITS-1:0] found_pos;
   step_type             step;

   assign rd_pat_addr  = k_in[IDX_BITS-1:0];
   assign rd_fail_addr = k_in[IDX_BITS-1:0] - IDX_BITS'(1);
   assign found_pos    = pos_ff + TPOS_BITS'(1) - TPOS_BITS'(pat_len_ff);

   kmpfm_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (MAX_PATTERN)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pat),
      .rd_addr (rd_pat_addr),
      .rd_data (pat_byte)
   );

   kmpfm_ram #(
      .WIDTH (LEN_BITS),
      .DEPTH (MAX_PATTERN)
   ) u_fail_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_fail),
      .rd_addr (rd_fail_addr),
      .rd_data (fail_k)
   );

   kmpfm_step u_step (
      .k        (k_ff),
      .pat_byte (pat_byte),
      .fail_k   (fail_k),
      .c        (c_ff),
      .limit    (pat_len_ff),
      .step     (step)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      pat_len_in   = pat_len_ff;
      pre_idx_in   = pre_idx_ff;
      match_in     = match_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      closed_in    = closed_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pat_len_ff[IDX_BITS-1:0];
      wr_pat       = c_ff;
      wr_fail      = step.next_k;
      eff_len      = closed_ff ? '0 : pat_len_ff;
      tail_en      = 1'b0;
      tail_last    = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               c_in      = req_data.data_byte;
               last_in   = req_data.last;
               tail_last = req_data.last;
               if (req_data.op == OP_PATTERN) begin
                  if (closed_ff) begin
                     pat_len_in = '0;
                     pre_idx_in = '0;
                     ovf_in     = 1'b0;
                     closed_in  = 1'b0;
                     pos_in     = '0;
                     match_in   = '0;
                     done_in    = 1'b0;
                  end
                  if (eff_len == LEN_BITS'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                     if (req_data.last) begin
                        closed_in = 1'b1;
                        pend_in   = '{status: ST_PAT_LONG, position: '0};
                        state_in  = S_EMIT;
                     end
                  end else if (eff_len == '0) begin
                     wr_en      = 1'b1;
                     wr_addr    = '0;
                     wr_pat     = req_data.data_byte;
                     wr_fail    = '0;
                     pat_len_in = LEN_BITS'(1);
                     pre_idx_in = '0;
                     if (req_data.last) begin
                        closed_in = 1'b1;
                     end
                  end else begin
                     k_in     = pre_idx_ff;
                     state_in = S_SCAN;
                  end
               end else begin
                  closed_in = 1'b1;
                  tail_en   = 1'b1;
                  if (done_ff) begin
                     done_in = 1'b1;
                  end else if (ovf_ff) begin
                     if (req_data.last) begin
                        pend_in  = '{status: ST_PAT_LONG, position: '0};
                        state_in = S_EMIT;
                     end
                  end else if (pos_ff[POSITION_BITS]) begin
                     done_in  = 1'b1;
                     pend_in  = '{status: ST_TEXT_LONG, position: '0};
                     state_in = S_EMIT;
                  end else if (pat_len_ff == '0) begin
                     done_in  = 1'b1;
                     pend_in  = '{status: ST_FOUND, position: '0};
                     state_in = S_EMIT;
                  end else begin
                     tail_en  = 1'b0;
                     k_in     = match_ff;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            k_in = step.next_k;
            if (!step.chase) begin
               state_in = S_IDLE;
               if (op_ff == OP_PATTERN) begin
                  wr_en      = 1'b1;
                  pat_len_in = pat_len_ff + LEN_BITS'(1);
                  pre_idx_in = step.next_k;
                  if (last_ff) begin
                     closed_in = 1'b1;
                  end
               end else begin
                  tail_en = 1'b1;
                  if (step.next_k >= pat_len_ff) begin
                     done_in  = 1'b1;
                     match_in = '0;
                     pend_in  = '{status: ST_FOUND,
                                  position: found_pos[POSITION_BITS-1:0]};
                     state_in = S_EMIT;
                  end else begin
                     match_in = step.next_k;
                     if (last_ff) begin
                        pend_in  = '{status: ST_NOT_FOUND, position: '0};
                        state_in = S_EMIT;
                     end
                  end
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (tail_en) begin
         if (!pos_ff[POSITION_BITS]) begin
            pos_in = pos_ff + TPOS_BITS'(1);
         end
         if (tail_last) begin
            pos_in   = '0;
            match_in = '0;
            done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pat_len_ff   <= '0;
         pre_idx_ff   <= '0;
         match_ff     <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pat_len_ff   <= pat_len_in;
         pre_idx_ff   <= pre_idx_in;
         match_ff     <= match_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      c_ff        <= c_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_scan_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (k_ff < pat_len_ff))
      else $error("prefix length out of range during scan");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      pat_len_ff <= LEN_BITS'(MAX_PATTERN))
      else $error("pattern length beyond store");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pat_len_ff == LEN_BITS'(MAX_PATTERN)))
      else $error("overflow flagged with room left in store");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_FOUND)) |-> (rsp_data_ff.position == '0))
      else $error("nonzero position on a response other than found");

endmodule

[tb/tb_kmp_first_match_search.sv]
// Testbench: drives pattern and text requests into the KMP first-match search and checks responses.
`timescale 1ns / 1ps
module tb_kmp_first_match_search;
   import kmpfm_pkg::*;

   localparam longint unsigned CYCLE_LIMIT = 64'd1_000_000;

   class first_match_tracker;
      localparam longint unsigned TEXT_SPAN = 64'd1 << POSITION_BITS;

      bit [7:0]        pat_bytes [MAX_PATTERN];
      int unsigned     fail_links [MAX_PATTERN];
      int unsigned     pat_len;
      int unsigned     border;
      int unsigned     matched;
      longint unsigned text_idx;
      bit              done;
      bit              overflow;
      bit              closed;
      rsp_type         pending_results [$];
      int unsigned     accepted;
      int unsigned     checked;
      int unsigned     errors;
      int unsigned     status_seen [4];

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void expect_result(logic [1:0] status, longint unsigned where);
         rsp_type r;
         r.status   = status;
         r.position = where[POSITION_BITS-1:0];
         pending_results.push_back(r);
      endfunction

      function void clear_text();
         text_idx = 0;
         matched  = 0;
         done     = 1'b0;
      endfunction

      function void load_pattern_byte(bit [7:0] c, bit fin);
         int unsigned j;
         if (closed) begin
            pat_len  = 0;
            border   = 0;
            overflow = 1'b0;
            closed   = 1'b0;
            clear_text();
         end
         j = pat_len;
         if (j >= MAX_PATTERN) begin
            overflow = 1'b1;
         end else begin
            if (j == 0) begin
               border = 0;
            end else begin
               while (border > 0 && border < MAX_PATTERN && pat_bytes[border] != c)
                  border = fail_links[border-1];
               if (border < j && pat_bytes[border] == c)
                  border++;
            end
            fail_links[j] = (j == 0) ? 0 : border;
            pat_bytes[j]  = c;
            pat_len       = j + 1;
         end
         if (fin) begin
            closed = 1'b1;
            if (overflow)
               expect_result(ST_PAT_LONG, 0);
         end
      endfunction

      function void scan_text_byte(bit [7:0] c, bit fin);
         int unsigned m;
         closed = 1'b1;
         if (done) begin
         end else if (overflow) begin
            if (fin)
               expect_result(ST_PAT_LONG, 0);
         end else if (text_idx >= TEXT_SPAN) begin
            done = 1'b1;
            expect_result(ST_TEXT_LONG, 0);
         end else if (pat_len == 0) begin
            done = 1'b1;
            expect_result(ST_FOUND, 0);
         end else begin
            m = matched;
            while (m > 0 && m < MAX_PATTERN && pat_bytes[m] != c)
               m = fail_links[m-1];
            if (m < pat_len && pat_bytes[m] == c)
               m++;
            if (m >= pat_len) begin
               done    = 1'b1;
               matched = 0;
               expect_result(ST_FOUND, text_idx + 1 - pat_len);
            end else begin
               matched = m;
               if (fin)
                  expect_result(ST_NOT_FOUND, 0);
            end
         end
         if (text_idx < TEXT_SPAN)
            text_idx++;
         if (fin)
            clear_text();
      endfunction

      function void note_request(req_type item);
         accepted++;
         if (item.op == OP_PATTERN)
            load_pattern_byte(item.data_byte, item.last);
         else
            scan_text_byte(item.data_byte, item.last);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected: status %0d position %0d",
                                      got.status, got.position));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d (status %0d)",
                                      got.position, want.position, want.status));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned     send_pct  = 23;
   int unsigned     recv_pct  = 68;
   bit              hold_go   = 1'b0;
   bit              hold_done = 1'b0;
   int unsigned     hold_left = 0;
   longint unsigned cycle_count = 0;

   first_match_tracker tracker;

   kmp_first_match_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_kmp_first_match_search failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_data);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   task automatic send_request(input logic op, input logic [7:0] value, input logic fin);
      req_type item;
      item.op        = op;
      item.data_byte = value;
      item.last      = fin;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(item);
   endtask

   // Random pattern/text sessions over a small alphabet so failure links get exercised.
   task automatic run_sessions(input int unsigned count);
      int unsigned goal;
      int unsigned alpha_n;
      int unsigned pat_n;
      int unsigned txt_n;
      int unsigned texts;
      int unsigned kind;
      int unsigned at;
      int unsigned roll;
      bit          close_last;
      logic [7:0]  alpha [3];
      logic [7:0]  pat [$];
      logic [7:0]  txt [$];
      goal = tracker.accepted + count;
      while (tracker.accepted < goal) begin
         alpha_n = $urandom_range(1, 3);
         foreach (alpha[k])
            alpha[k] = $urandom_range(255);
         roll = $urandom_range(99);
         if (roll < 70)
            pat_n = $urandom_range(1, 6);
         else if (roll < 92)
            pat_n = $urandom_range(7, 20);
         else if (roll < 97)
            pat_n = $urandom_range(21, MAX_PATTERN);
         else
            pat_n = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
         pat.delete();
         for (int k = 0; k < pat_n; k++)
            pat.push_back(alpha[$urandom_range(alpha_n - 1)]);
         close_last = ($urandom_range(3) != 0);
         for (int k = 0; k < pat_n; k++)
            send_request(OP_PATTERN, pat[k], close_last && (k == pat_n - 1));
         texts = $urandom_range(1, 3);
         for (int t = 0; t < texts; t++) begin
            kind  = $urandom_range(9);
            txt_n = $urandom_range(1, 30);
            txt.delete();
            for (int k = 0; k < txt_n; k++)
               txt.push_back((kind == 0) ? 8'($urandom_range(255))
                                         : alpha[$urandom_range(alpha_n - 1)]);
            if (kind >= 5 && pat_n <= MAX_PATTERN) begin
               at = $urandom_range(txt_n);
               for (int k = 0; k < pat_n; k++) begin
                  if (at + k < txt.size())
                     txt[at + k] = pat[k];
                  else
                     txt.push_back(pat[k]);
               end
            end
            foreach (txt[k])
               send_request(OP_TEXT, txt[k], k == txt.size() - 1);
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pattern, then a trailing byte that is ignored
      send_request(OP_TEXT, 8'h00, 1'b0);
      send_request(OP_TEXT, 8'hFF, 1'b1);
      // pattern with a self-overlap, match in the middle of the text
      send_request(OP_PATTERN, 8'h00, 1'b0);
      send_request(OP_PATTERN, 8'hFF, 1'b0);
      send_request(OP_PATTERN, 8'h00, 1'b1);
      send_request(OP_TEXT, 8'hFF, 1'b0);
      send_request(OP_TEXT, 8'h00, 1'b0);
      send_request(OP_TEXT, 8'hFF, 1'b0);
      send_request(OP_TEXT, 8'h00, 1'b0);
      send_request(OP_TEXT, 8'hFF, 1'b1);
      // no match
      send_request(OP_TEXT, 8'h00, 1'b0);
      send_request(OP_TEXT, 8'hFF, 1'b1);
      // open pattern closed by the first text byte
      send_request(OP_PATTERN, 8'h80, 1'b0);
      send_request(OP_TEXT, 8'h01, 1'b0);
      send_request(OP_TEXT, 8'h80, 1'b1);
      // match on the last byte of the text
      send_request(OP_PATTERN, 8'h7F, 1'b1);
      send_request(OP_TEXT, 8'h7F, 1'b1);
      // over-long pattern and a text against it
      for (int k = 0; k < MAX_PATTERN + 2; k++)
         send_request(OP_PATTERN, 8'(k % 4), k == MAX_PATTERN + 1);
      send_request(OP_TEXT, 8'h01, 1'b0);
      send_request(OP_TEXT, 8'h02, 1'b1);

      run_sessions(270);
      send_pct <= 68;
      recv_pct <= 23;
      run_sessions(270);
      send_pct <= 0;
      recv_pct <= 0;
      hold_go  <= 1'b1;
      run_sessions(270);
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("%0d requests in, %0d responses checked (found %0d, not found %0d, %0s %0d, %0s %0d)",
               tracker.accepted, tracker.checked, tracker.status_seen[ST_FOUND],
               tracker.status_seen[ST_NOT_FOUND], "pattern too long",
               tracker.status_seen[ST_PAT_LONG], "text too long",
               tracker.status_seen[ST_TEXT_LONG]);
      $display("mixed idling on both sides, a long response hold-off, %0d mismatches",
               tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("tb_kmp_first_match_search passed");
      else
         $display("tb_kmp_first_match_search failed");
      $finish;
   end

endmodule

[files.f]
hdl/kmpfm_pkg.sv
hdl/kmpfm_ram.sv
hdl/kmpfm_step.sv
hdl/kmp_first_match_search.sv
tb/tb_kmp_first_match_search.sv
